// ===== hw/rtl/mapt_pkg.sv =====
// Shared types and constants for the MAC address peer table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mapt_pkg;

	localparam int MAC_W   = 48;
	localparam int CMD_W   = 2;
	localparam int TOTAL_W = 5;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic load;
		logic cmp;
		logic upd;
	} mapt_ctl_t;

	typedef struct packed {
		logic out_free;
	} mapt_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mapt_ctrl.sv =====
// Sequencing state machine for the MAC address peer table.
// Drives datapath commands from mapt_pkg::mapt_ctl_t; reads mapt_pkg::mapt_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module mapt_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  mapt_pkg::mapt_sts_t     sts,
	output mapt_pkg::mapt_ctl_t     ctl
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   stall_q;

	assign in_stall = stall_q;

	always_comb begin
		ctl.load = in_valid && !stall_q;
		ctl.cmp  = (state_q == ST_CMP);
		ctl.upd  = (state_q == ST_UPD) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !stall_q) begin
						state_q <= ST_CMP;
						stall_q <= 1'b1;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stall_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					stall_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mapt_dp.sv =====
// Datapath of the MAC address peer table: request register, compare cells,
// packed slot row with shift-down on remove, and the result register. Uses mapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mapt_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  mapt_pkg::mapt_ctl_t                 ctl,
	output mapt_pkg::mapt_sts_t                 sts,
	input  wire logic [mapt_pkg::CMD_W-1:0]     cmd,
	input  wire logic [mapt_pkg::MAC_W-1:0]     mac,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit,
	output logic                                done_res,
	output logic [mapt_pkg::TOTAL_W-1:0]        entry_total
);

	localparam int CntW = $clog2(MAX_ENTRIES + 1);

	logic [mapt_pkg::CMD_W-1:0] req_cmd_q;
	logic [mapt_pkg::MAC_W-1:0] req_mac_q;
	logic [mapt_pkg::MAC_W-1:0] slot_q [MAX_ENTRIES];
	logic [CntW-1:0]            count_q;
	logic [MAX_ENTRIES-1:0]     match_s1;
	logic [MAX_ENTRIES-1:0]     match_now;
	logic [MAX_ENTRIES-1:0]     at_or_above;
	logic [MAX_ENTRIES-1:0]     shift_en;
	logic [MAX_ENTRIES-1:0]     wr_en;

	logic                       out_valid_q;
	logic                       hit_q;
	logic                       done_q;
	logic [mapt_pkg::TOTAL_W-1:0] total_q;

	logic is_add;
	logic is_rem;
	logic any_hit;
	logic full;
	logic add_ok;
	logic rem_ok;
	logic [CntW-1:0] count_next;

	assign is_add  = (req_cmd_q == mapt_pkg::CMD_ADD);
	assign is_rem  = (req_cmd_q == mapt_pkg::CMD_REMOVE);
	assign any_hit = |match_s1;
	assign full    = (count_q == CntW'(MAX_ENTRIES));
	assign add_ok  = is_add && !any_hit && !full;
	assign rem_ok  = is_rem && any_hit;

	always_comb begin
		count_next = count_q;
		if (add_ok) begin
			count_next = count_q + CntW'(1);
		end else if (rem_ok) begin
			count_next = count_q - CntW'(1);
		end
	end

	for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
		assign match_now[j]   = (slot_q[j] == req_mac_q) && (CntW'(j) < count_q);
		assign at_or_above[j] = |match_s1[j:0];
		assign wr_en[j]       = add_ok && (count_q == CntW'(j));
		if (j < MAX_ENTRIES - 1) begin : g_shift
			assign shift_en[j] = rem_ok && at_or_above[j] && (CntW'(j + 1) < count_q);
			always_ff @(posedge clk) begin
				if (ctl.upd && shift_en[j]) begin
					slot_q[j] <= slot_q[j + 1];
				end else if (ctl.upd && wr_en[j]) begin
					slot_q[j] <= req_mac_q;
				end
			end
		end else begin : g_top
			assign shift_en[j] = 1'b0;
			always_ff @(posedge clk) begin
				if (ctl.upd && wr_en[j] && !shift_en[j]) begin
					slot_q[j] <= req_mac_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_cmd_q <= cmd;
			req_mac_q <= mac;
		end
		if (ctl.cmp) begin
			match_s1 <= match_now;
		end
		if (ctl.upd) begin
			hit_q   <= any_hit;
			done_q  <= any_hit || add_ok;
			total_q <= mapt_pkg::TOTAL_W'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.upd) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign done_res     = done_q;
	assign entry_total  = total_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mac_address_peer_table_core.sv =====
// Top level of the MAC address peer table: joins mapt_ctrl and mapt_dp.
// Depends on mapt_pkg, mapt_ctrl and mapt_dp.
//
//   channel | ports                                   | direction
//   request | in_valid, in_stall, cmd, mac            | into block
//   result  | out_valid, out_stall, hit, done_res,    | out of block
//           | entry_total                             |
//
// Each request passes through accept, a parallel compare over all slots,
// then an update of the slot row and count. Reset clears the count, the
// result valid flag and the request stall; slot contents stay undefined
// until written. A result held by out_stall keeps the next request in the
// update cycle until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module mac_address_peer_table_core #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [mapt_pkg::CMD_W-1:0]     cmd,
	input  wire logic [mapt_pkg::MAC_W-1:0]     mac,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit,
	output logic                                done_res,
	output logic [mapt_pkg::TOTAL_W-1:0]        entry_total
);

	mapt_pkg::mapt_ctl_t ctl;
	mapt_pkg::mapt_sts_t sts;

	mapt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	mapt_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.cmd         (cmd),
		.mac         (mac),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.done_res    (done_res),
		.entry_total (entry_total)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mapt_chk.sv =====
// Port-level checks for the MAC address peer table and their bind.
// Observes mac_address_peer_table_core ports only; depends on mapt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mapt_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic                           hit,
	input wire logic                           done_res,
	input wire logic [mapt_pkg::TOTAL_W-1:0]   entry_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(done_res)
			&& $stable(entry_total))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another is in work");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> done_res)
		else $error("hit without success");

	a_result_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a request in work");

endmodule

bind mac_address_peer_table_core mapt_chk u_mapt_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.hit         (hit),
	.done_res    (done_res),
	.entry_total (entry_total)
);

`default_nettype wire
